// ===== rtl/core/upd_pkg.sv =====
package upd_pkg;

    // character codes
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LC_A    = 8'h61;
    localparam logic [7:0] CHAR_LC_F    = 8'h66;
    localparam logic [7:0] CHAR_UC_A    = 8'h41;
    localparam logic [7:0] CHAR_UC_F    = 8'h46;

    // escape tracking codes
    localparam logic [1:0] PEND_IDLE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_FIRST = 2'd2;

    // result queue sizing
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       error;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] pending;
        logic [7:0] held;
        logic       push_one;
        logic       push_two;
        result_t    res0;
        result_t    res1;
    } dec_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            h.value = 4'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_LC_A && c <= CHAR_LC_F)
        begin
            h.value = 4'(c - CHAR_LC_A + 8'd10);
        end
        else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
        begin
            h.value = 4'(c - CHAR_UC_A + 8'd10);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic [7:0] plus_to_space(input logic [7:0] c);
        return (c == CHAR_PLUS) ? CHAR_SPACE : c;
    endfunction

endpackage

// ===== rtl/core/upd_decode.sv =====
module upd_decode
(
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic [1:0]     pending,
    input  logic [7:0]     held,
    output upd_pkg::dec_t  dec
);

    upd_pkg::hex_t ha;
    upd_pkg::hex_t hb;
    logic          pair_ok;
    logic [7:0]    pair_val;

    // pair parse, base-16 integer style
    always_comb
    begin
        ha       = upd_pkg::hex_val(held);
        hb       = upd_pkg::hex_val(in_byte);
        pair_ok  = 1'b0;
        pair_val = 8'd0;
        if (ha.valid)
        begin
            pair_ok  = 1'b1;
            pair_val = hb.valid ? {ha.value, hb.value} : {4'd0, ha.value};
        end
        else if (hb.valid)
        begin
            if (upd_pkg::is_ws(held) || held == upd_pkg::CHAR_PLUS)
            begin
                pair_ok  = 1'b1;
                pair_val = {4'd0, hb.value};
            end
            else if (held == upd_pkg::CHAR_MINUS)
            begin
                pair_ok  = 1'b1;
                pair_val = 8'(8'd0 - {4'd0, hb.value});
            end
        end
    end

    // next state and results
    always_comb
    begin
        dec.pending    = upd_pkg::PEND_IDLE;
        dec.held       = held;
        dec.push_one   = 1'b0;
        dec.push_two   = 1'b0;
        dec.res0.data  = upd_pkg::plus_to_space(in_byte);
        dec.res0.error = 1'b0;
        dec.res0.last  = in_last;
        dec.res1.data  = upd_pkg::plus_to_space(in_byte);
        dec.res1.error = 1'b0;
        dec.res1.last  = 1'b1;
        case (pending)
            upd_pkg::PEND_PCT:
            begin
                if (!in_last)
                begin
                    dec.held    = in_byte;
                    dec.pending = upd_pkg::PEND_FIRST;
                end
                else
                begin
                    // escape cut short: literal percent, then the last byte
                    dec.push_one   = 1'b1;
                    dec.push_two   = 1'b1;
                    dec.res0.data  = upd_pkg::CHAR_PERCENT;
                    dec.res0.last  = 1'b0;
                end
            end
            upd_pkg::PEND_FIRST:
            begin
                dec.held       = 8'd0;
                dec.push_one   = 1'b1;
                dec.res0.data  = pair_ok ? pair_val : 8'd0;
                dec.res0.error = !pair_ok;
            end
            default:
            begin
                if (in_byte == upd_pkg::CHAR_PERCENT && !in_last)
                begin
                    dec.pending = upd_pkg::PEND_PCT;
                end
                else
                begin
                    dec.push_one = 1'b1;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/upd_out_queue.sv =====
module upd_out_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_one,
    input  logic              push_two,
    input  upd_pkg::result_t  res0,
    input  upd_pkg::result_t  res1,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output upd_pkg::result_t  head
);

    upd_pkg::result_t                entry_reg [upd_pkg::OUT_DEPTH];
    logic [upd_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [upd_pkg::PTR_W-1:0]       wr_ptr_next;
    logic [upd_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [upd_pkg::PTR_W-1:0]       rd_ptr_next;
    logic [upd_pkg::CNT_W-1:0]       count_reg;
    logic [upd_pkg::CNT_W-1:0]       count_next;
    logic [upd_pkg::PTR_W-1:0]       wr_ptr_plus1;
    logic [1:0]                      push_n;
    logic                            pop;

    // room for two results keeps one byte per cycle flowing while the output side drains
    assign has_room  = count_reg <= upd_pkg::CNT_W'(upd_pkg::OUT_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        push_n       = {push_two, push_one && !push_two};
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + upd_pkg::PTR_W'(push_n);
        rd_ptr_next  = rd_ptr_reg + upd_pkg::PTR_W'(pop);
        count_next   = count_reg + upd_pkg::CNT_W'(push_n) - upd_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push_one)
        begin
            entry_reg[wr_ptr_reg] <= res0;
        end
        if (push_two)
        begin
            entry_reg[wr_ptr_plus1] <= res1;
        end
    end

endmodule

// ===== rtl/core/url_percent_decoder.sv =====
// URL percent decoder: takes one raw byte per transfer and returns the decoded
// stream, '+' as space and "%xy" as one byte parsed like base-16 stoi
// (leading whitespace, '+' or '-' honoured, error result with zero data when
// the pair cannot be parsed). A byte is taken every cycle while there is room;
// the escape decode is a single combinational step against the held state, and
// results collect in a four-entry queue that takes input only while it has
// room for two results, so a stalled output side holds the input off once
// three or four results are queued.
module url_percent_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       error,
    output logic       out_last
);

    logic [1:0]        pending_reg;
    logic [7:0]        held_reg;
    upd_pkg::dec_t     dec;
    upd_pkg::result_t  head;
    logic              has_room;
    logic              accept;

    assign in_ready = has_room;
    assign accept   = in_valid && has_room;

    // escape decode
    upd_decode u_decode
    (
        .in_byte (in_byte),
        .in_last (in_last),
        .pending (pending_reg),
        .held    (held_reg),
        .dec     (dec)
    );

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= upd_pkg::PEND_IDLE;
            held_reg    <= 8'd0;
        end
        else if (accept)
        begin
            pending_reg <= dec.pending;
            held_reg    <= dec.held;
        end
    end

    // result queue
    upd_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_one  (accept && dec.push_one),
        .push_two  (accept && dec.push_two),
        .res0      (dec.res0),
        .res1      (dec.res1),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte = head.data;
    assign error    = head.error;
    assign out_last = head.last;

endmodule
